>>> src/sem_pkg.sv
`timescale 1ns / 1ps

package sem_pkg;

    localparam int PIX_W          = 8;
    localparam int MAX_LINE_WIDTH = 1024;
    localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
    localparam int ROW_W          = 12;
    localparam int WIDTH_W        = 11;
    localparam int HEIGHT_W       = 12;
    localparam int CFG_DATA_W     = 12;
    localparam int CFG_IDX_W      = 1;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int GRAD_W         = 11;   // signed difference of two 10-bit sums

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = 11'd3;
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = 11'(MAX_LINE_WIDTH);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = 12'd3;
    localparam logic [PIX_W-1:0]    PIX_MAX      = 8'd255;

    typedef logic [PIX_W-1:0] t_pix;

    // last column / last row indexes of the frame, already clamped
    typedef struct packed {
        logic [COL_W-1:0] last_col;
        logic [ROW_W-1:0] last_row;
    } t_geom;

    // window row-major: p[row*3 + col], col 2 newest
    typedef struct packed {
        t_pix [8:0] p;
        logic       eof;
    } t_win_item;

endpackage

>>> src/sem_front.sv
`timescale 1ns / 1ps

module sem_front import sem_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_geom      i_geom,
    input  logic       i_accept,
    input  t_pix       i_pixel,
    input  logic       i_start_of_frame,
    output logic       o_push,
    output t_win_item  o_item,
    output logic       o_inflight
);

    logic [COL_W-1:0]       r_col, n_col;
    logic [ROW_W-1:0]       r_row, n_row;
    logic [COL_W-1:0]       cur_col;
    logic [ROW_W-1:0]       cur_row;

    // line memory: {older line, newer line} per column
    logic [2*PIX_W-1:0]     r_line_mem [MAX_LINE_WIDTH];
    logic [2*PIX_W-1:0]     r_rd;

    logic                   r_s1_valid;
    logic                   r_s1_emit;
    logic                   r_s1_eof;
    logic [COL_W-1:0]       r_s1_col;
    t_pix                   r_s1_px;

    t_pix [8:0]             r_win, n_win;

    always_comb begin
        cur_col = i_start_of_frame ? '0 : r_col;
        cur_row = i_start_of_frame ? '0 : r_row;
        if (cur_col >= i_geom.last_col) begin
            n_col = '0;
            n_row = (cur_row >= i_geom.last_row) ? '0 : cur_row + 1'b1;
        end else begin
            n_col = cur_col + 1'b1;
            n_row = cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_accept;
            if (i_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_emit <= (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
            r_s1_eof  <= (cur_row >= i_geom.last_row) && (cur_col >= i_geom.last_col);
            r_s1_col  <= cur_col;
            r_s1_px   <= i_pixel;
        end
    end

    // read at transfer, write back on the following cycle; bypass when the same
    // column comes back on the very next transfer (start of frame repeats)
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_line_mem[r_s1_col] <= {r_rd[PIX_W-1:0], r_s1_px};
        end
        if (i_accept) begin
            if (r_s1_valid && (r_s1_col == cur_col)) begin
                r_rd <= {r_rd[PIX_W-1:0], r_s1_px};
            end else begin
                r_rd <= r_line_mem[cur_col];
            end
        end
    end

    always_comb begin
        n_win    = r_win;
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[2] = r_rd[2*PIX_W-1:PIX_W];
        n_win[5] = r_rd[PIX_W-1:0];
        n_win[8] = r_s1_px;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_s1_valid) begin
            r_win <= n_win;
        end
    end

    assign o_push     = r_s1_valid && r_s1_emit;
    assign o_item.p   = n_win;
    assign o_item.eof = r_s1_eof;
    assign o_inflight = o_push;

endmodule

>>> src/sem_queue.sv
`timescale 1ns / 1ps

module sem_queue import sem_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_win_item         i_data,
    input  logic              i_pop,
    output logic              o_empty,
    output t_win_item         o_data,
    output logic [QCNT_W-1:0] o_count
);

    t_win_item           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

>>> src/sem_back.sv
`timescale 1ns / 1ps

module sem_back import sem_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_win_item  i_item,
    output logic       o_take,
    input  logic       i_pop,
    output logic       o_empty,
    output t_pix       o_magnitude,
    output logic       o_end_of_frame
);

    logic                       r_b1_valid;
    logic signed [GRAD_W-1:0]   r_grow;
    logic signed [GRAD_W-1:0]   r_gcol;
    logic                       r_b1_eof;

    logic                       r_b2_valid;
    t_pix                       r_mag;
    logic                       r_b2_eof;

    logic                       b2_ready;
    logic                       b1_ready;
    logic [GRAD_W-2:0]          s_top, s_bot, s_left, s_right;
    logic [GRAD_W-2:0]          abs_r, abs_c;
    t_pix                       clamp_r, clamp_c;
    logic [PIX_W:0]             sum;

    assign b2_ready = !r_b2_valid || i_pop;
    assign b1_ready = !r_b1_valid || b2_ready;
    assign o_take   = i_valid && b1_ready;

    // weighted row and column sums, max 4*255 fits 10 bits
    always_comb begin
        s_top   = {2'b0, i_item.p[0]} + {1'b0, i_item.p[1], 1'b0} + {2'b0, i_item.p[2]};
        s_bot   = {2'b0, i_item.p[6]} + {1'b0, i_item.p[7], 1'b0} + {2'b0, i_item.p[8]};
        s_left  = {2'b0, i_item.p[0]} + {1'b0, i_item.p[3], 1'b0} + {2'b0, i_item.p[6]};
        s_right = {2'b0, i_item.p[2]} + {1'b0, i_item.p[5], 1'b0} + {2'b0, i_item.p[8]};
    end

    always_comb begin
        abs_r   = r_grow[GRAD_W-1] ? (GRAD_W-1)'(-r_grow) : r_grow[GRAD_W-2:0];
        abs_c   = r_gcol[GRAD_W-1] ? (GRAD_W-1)'(-r_gcol) : r_gcol[GRAD_W-2:0];
        clamp_r = (abs_r > {2'b0, PIX_MAX}) ? PIX_MAX : abs_r[PIX_W-1:0];
        clamp_c = (abs_c > {2'b0, PIX_MAX}) ? PIX_MAX : abs_c[PIX_W-1:0];
        sum     = {1'b0, clamp_r} + {1'b0, clamp_c};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
        end else begin
            if (b1_ready) begin
                r_b1_valid <= i_valid;
            end
            if (b2_ready) begin
                r_b2_valid <= r_b1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_grow   <= $signed({1'b0, s_top})  - $signed({1'b0, s_bot});
            r_gcol   <= $signed({1'b0, s_left}) - $signed({1'b0, s_right});
            r_b1_eof <= i_item.eof;
        end
        if (b2_ready && r_b1_valid) begin
            r_mag    <= sum[PIX_W] ? PIX_MAX : sum[PIX_W-1:0];
            r_b2_eof <= r_b1_eof;
        end
    end

    assign o_empty        = !r_b2_valid;
    assign o_magnitude    = r_mag;
    assign o_end_of_frame = r_b2_eof;

endmodule

>>> src/sobel_edge_magnitude_stream_core.sv
`timescale 1ns / 1ps
// 3x3 Sobel edge magnitude over a raster pixel stream.
// Input side is a queue: drive i_pixel / i_start_of_frame with i_push; a
// transfer happens when i_push is high and o_full is low. One pixel per
// cycle is sustained while o_full is low. i_start_of_frame puts the pixel
// at row 0, column 0; else position wraps itself after a frame's last pixel.
// Output side is a queue: while o_empty is low the oldest result sits on
// o_magnitude / o_end_of_frame and i_pop takes it. Only interior pixels give
// a result; o_end_of_frame flags the last interior pixel of the frame.
// A result passes the front register, window queue and back end. Throughput
// is one result per cycle while i_pop keeps up, set by the single read/write
// port pair of the line memory (one column per cycle). A stalled output fills
// the 4-entry window queue; o_full then rises while pixels already in flight
// still find room. Results are never dropped. Geometry registers (index 0
// width, 1 height) are written through i_cfg_we / i_cfg_idx / i_cfg_data;
// the user must write them only while the block is idle (not enforced).
// Reset: position counters and window clear, width 640, height 480, queues
// empty. Line memory holds no reset value; no clearing pass is run.

module sobel_edge_magnitude_stream_core import sem_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [PIX_W-1:0]      i_pixel,
    input  logic                  i_start_of_frame,
    output logic                  o_empty,
    input  logic                  i_pop,
    output logic [PIX_W-1:0]      o_magnitude,
    output logic                  o_end_of_frame
);

    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [WIDTH_W-1:0]  eff_width;
    logic [HEIGHT_W-1:0] eff_height;
    t_geom               geom;

    logic                accept;
    logic                f_push;
    logic                f_inflight;
    t_win_item           f_item;
    logic                q_empty;
    t_win_item           q_item;
    logic [QCNT_W-1:0]   q_count;
    logic                b_take;
    logic [QCNT_W:0]     occupancy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (r_width < WIDTH_MIN) begin
            eff_width = WIDTH_MIN;
        end else if (r_width > WIDTH_MAX) begin
            eff_width = WIDTH_MAX;
        end else begin
            eff_width = r_width;
        end
        eff_height    = (r_height < HEIGHT_MIN) ? HEIGHT_MIN : r_height;
        geom.last_col = COL_W'(eff_width - 1'b1);
        geom.last_row = ROW_W'(eff_height - 1'b1);
    end

    // count the window still on its way into the queue
    assign occupancy = {1'b0, q_count} + {{QCNT_W{1'b0}}, f_inflight};
    assign o_full    = occupancy >= (QCNT_W+1)'(QUEUE_DEPTH);
    assign accept    = i_push && !o_full;

    sem_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_geom           (geom),
        .i_accept         (accept),
        .i_pixel          (i_pixel),
        .i_start_of_frame (i_start_of_frame),
        .o_push           (f_push),
        .o_item           (f_item),
        .o_inflight       (f_inflight)
    );

    sem_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_item),
        .i_pop   (b_take),
        .o_empty (q_empty),
        .o_data  (q_item),
        .o_count (q_count)
    );

    sem_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (!q_empty),
        .i_item         (q_item),
        .o_take         (b_take),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_magnitude    (o_magnitude),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule
